// ===== sv/qte_pkg.sv =====
// Shared types, constants and functions of the quaternion to Euler angle converter.
package qte_pkg;

	localparam int PW = 34;
	localparam int SW = 36;
	localparam int XW = 40;
	localparam int ZW = 34;
	localparam int NW = 61;
	localparam int RW = 62;
	localparam int CW = 18;

	localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
	localparam logic signed [47:0] CD_PER_RAD = 48'sd5730;
	localparam logic signed [47:0] CD_ROUND = 48'sd536870912;
	localparam logic signed [SW-1:0] Q30_ONE = 36'sd1073741824;
	localparam logic [NW-1:0] Q60_ONE = 61'd1 << 60;

	typedef logic signed [XW-1:0] cx_t;
	typedef logic signed [ZW-1:0] ang_t;
	typedef logic signed [SW-1:0] sum_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} lane_t;

	typedef struct packed {
		logic signed [31:0] s;
		logic clip;
		logic signed [SW-1:0] rx;
		logic signed [SW-1:0] ry;
		logic signed [SW-1:0] yx;
		logic signed [SW-1:0] yy;
	} dly_t;

	function automatic ang_t atan_entry(input int i);
		ang_t a;
		case (i)
			0: a = 34'sd843314856;
			1: a = 34'sd497837829;
			2: a = 34'sd263043836;
			3: a = 34'sd133525158;
			4: a = 34'sd67021686;
			5: a = 34'sd33543515;
			6: a = 34'sd16775850;
			7: a = 34'sd8388437;
			8: a = 34'sd4194282;
			9: a = 34'sd2097149;
			10: a = 34'sd1048575;
			default: begin
				if (i < 30) a = (34'sd1 <<< (30 - i)) - 34'sd1;
				else a = '0;
			end
		endcase
		return a;
	endfunction

	function automatic lane_t prerot(input cx_t y, input cx_t x);
		lane_t l;
		l.zero = (x == 0) && (y == 0);
		if (x < 0) begin
			if (y >= 0) begin
				l.x = y;
				l.y = -x;
				l.z = HALF_PI;
			end else begin
				l.x = -y;
				l.y = x;
				l.z = -HALF_PI;
			end
		end else begin
			l.x = x;
			l.y = y;
			l.z = '0;
		end
		return l;
	endfunction

endpackage

// ===== sv/qte_sqrt_cell.sv =====
// One cell of the pipelined integer square root, settling one result bit.
module qte_sqrt_cell #(
	parameter int K = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [qte_pkg::NW-1:0] n_i,
	input  logic [qte_pkg::RW-1:0] r_i,
	output logic [qte_pkg::NW-1:0] n_o,
	output logic [qte_pkg::RW-1:0] r_o
);
	import qte_pkg::*;

	localparam logic [RW-1:0] BIT = 62'd1 << (2 * K);

	logic [RW-1:0] t;

	assign t = r_i + BIT;

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, n_i} >= t) begin
				n_o <= n_i - t[NW-1:0];
				r_o <= (r_i >> 1) + BIT;
			end else begin
				n_o <= n_i;
				r_o <= r_i >> 1;
			end
		end
	end

endmodule

// ===== sv/qte_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation cell.
module qte_cordic_cell #(
	parameter int I = 0
) (
	input  logic clk,
	input  logic en,
	input  qte_pkg::lane_t lane_i,
	output qte_pkg::lane_t lane_o
);
	import qte_pkg::*;

	localparam ang_t ATAN = atan_entry(I);

	cx_t dx;
	cx_t dy;
	lane_t nx;

	always_comb begin
		dx = lane_i.y >>> I;
		dy = lane_i.x >>> I;
		nx = lane_i;
		if (lane_i.y > 0) begin
			nx.x = lane_i.x + dx;
			nx.y = lane_i.y - dy;
			nx.z = lane_i.z + ATAN;
		end else begin
			nx.x = lane_i.x - dx;
			nx.y = lane_i.y + dy;
			nx.z = lane_i.z - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) lane_o <= nx;
	end

endmodule

// ===== sv/quaternion_to_euler_angles.sv =====
// Top level of the quaternion to Euler angle converter.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | quat_w, quat_x, quat_y, quat_z, quat_present
//  out     | output    | out_valid/out_stall | pitch, roll, yaw centidegrees, asin_clamped
//
// One transaction is taken every cycle while in_stall is low; a result passes through the
// 31-cell square root chain followed by the CORDIC cell chain.
// A transaction with quat_present low leaves a bubble and yields no result.
// Reset clears only the valid bits; payload registers are not reset.
// A skid register holds one result while out_stall is high; in_stall rises only when it is full.
module quaternion_to_euler_angles #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	input  logic quat_present,
	output logic out_valid,
	input  logic out_stall,
	output logic [14:0] pitch_centideg,
	output logic signed [15:0] roll_centideg,
	output logic signed [15:0] yaw_centideg,
	output logic asin_clamped
);
	import qte_pkg::*;

	localparam int NSTEP = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
	localparam int NSQ = 31;
	localparam int DLY = NSQ + 2;

	logic en;

	logic signed [63:0] m_wy, m_xz, m_yz, m_wx, m_xy, m_wz, m_xx, m_yy, m_ww, m_zz;
	logic signed [PW-1:0] wy_s1, xz_s1, yz_s1, wx_s1, xy_s1, wz_s1, xx_s1, yy_s1, ww_s1, zz_s1;
	logic v_s1;

	sum_t s_raw;
	dly_t d_in;

	dly_t dly_q [0:DLY];
	logic dly_v_q [0:DLY];

	logic signed [31:0] s_abs;
	logic [30:0] sa;
	logic [RW-1:0] sq_s3;
	logic [NW-1:0] n_s4;

	logic [NW-1:0] sq_n [0:NSQ];
	logic [RW-1:0] sq_r [0:NSQ];

	lane_t pre_q [0:2];
	lane_t cl [0:NSTEP][0:2];
	logic cv_q [0:NSTEP];
	logic cc_q [0:NSTEP];

	logic signed [47:0] m_cd [0:2];
	logic signed [CW-1:0] cd_s6 [0:2];
	logic v_s6;
	logic clip_s6;

	logic signed [19:0] pitch_w, roll_w, yaw_w;
	logic [14:0] pitch_s7;
	logic signed [15:0] roll_s7, yaw_s7;
	logic clip_s7;
	logic v_s7;

	logic out_v_q;
	logic [14:0] out_pitch_q;
	logic signed [15:0] out_roll_q, out_yaw_q;
	logic out_clip_q;
	logic skid_v_q;
	logic [14:0] skid_pitch_q;
	logic signed [15:0] skid_roll_q, skid_yaw_q;
	logic skid_clip_q;
	logic out_ready;

	assign en = !skid_v_q;
	assign in_stall = skid_v_q;

	assign m_wy = quat_w * quat_y;
	assign m_xz = quat_x * quat_z;
	assign m_yz = quat_y * quat_z;
	assign m_wx = quat_w * quat_x;
	assign m_xy = quat_x * quat_y;
	assign m_wz = quat_w * quat_z;
	assign m_xx = quat_x * quat_x;
	assign m_yy = quat_y * quat_y;
	assign m_ww = quat_w * quat_w;
	assign m_zz = quat_z * quat_z;

	always_ff @(posedge clk) begin
		if (en) begin
			wy_s1 <= m_wy[63:30];
			xz_s1 <= m_xz[63:30];
			yz_s1 <= m_yz[63:30];
			wx_s1 <= m_wx[63:30];
			xy_s1 <= m_xy[63:30];
			wz_s1 <= m_wz[63:30];
			xx_s1 <= m_xx[63:30];
			yy_s1 <= m_yy[63:30];
			ww_s1 <= m_ww[63:30];
			zz_s1 <= m_zz[63:30];
		end
	end

	always_comb begin
		s_raw = (SW'(wy_s1) - SW'(xz_s1)) <<< 1;
		d_in.clip = 1'b0;
		if (s_raw > Q30_ONE) begin
			d_in.s = 32'sd1073741824;
			d_in.clip = 1'b1;
		end else if (s_raw < -Q30_ONE) begin
			d_in.s = -32'sd1073741824;
			d_in.clip = 1'b1;
		end else begin
			d_in.s = s_raw[31:0];
		end
		d_in.ry = (SW'(yz_s1) + SW'(wx_s1)) <<< 1;
		d_in.rx = Q30_ONE - (SW'(xx_s1) <<< 1) - (SW'(yy_s1) <<< 1);
		d_in.yy = (SW'(xy_s1) + SW'(wz_s1)) <<< 1;
		d_in.yx = SW'(ww_s1) + SW'(xx_s1) - SW'(yy_s1) - SW'(zz_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= d_in;
			for (int k = 1; k <= DLY; k++) dly_q[k] <= dly_q[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= DLY; k++) dly_v_q[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && quat_present;
			dly_v_q[0] <= v_s1;
			for (int k = 1; k <= DLY; k++) dly_v_q[k] <= dly_v_q[k-1];
		end
	end

	assign s_abs = (dly_q[0].s < 0) ? -dly_q[0].s : dly_q[0].s;
	assign sa = s_abs[30:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s3 <= RW'(sa) * RW'(sa);
			n_s4 <= Q60_ONE - sq_s3[NW-1:0];
		end
	end

	assign sq_n[0] = n_s4;
	assign sq_r[0] = '0;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		qte_sqrt_cell #(.K(NSQ - 1 - k)) u_cell (
			.clk(clk),
			.en(en),
			.n_i(sq_n[k]),
			.r_i(sq_r[k]),
			.n_o(sq_n[k+1]),
			.r_o(sq_r[k+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_q[0] <= prerot(XW'(dly_q[DLY].s), cx_t'({{(XW-31){1'b0}}, sq_r[NSQ][30:0]}));
			pre_q[1] <= prerot(XW'(dly_q[DLY].ry), XW'(dly_q[DLY].rx));
			pre_q[2] <= prerot(XW'(dly_q[DLY].yy), XW'(dly_q[DLY].yx));
			cc_q[0] <= dly_q[DLY].clip;
			for (int i = 1; i <= NSTEP; i++) cc_q[i] <= cc_q[i-1];
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_pre
		assign cl[0][j] = pre_q[j];
	end

	for (genvar i = 0; i < NSTEP; i++) begin : g_stage
		for (genvar j = 0; j < 3; j++) begin : g_lane
			qte_cordic_cell #(.I(i)) u_cell (
				.clk(clk),
				.en(en),
				.lane_i(cl[i][j]),
				.lane_o(cl[i+1][j])
			);
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			m_cd[j] = (cl[NSTEP][j].zero ? 48'sd0 : 48'(cl[NSTEP][j].z)) * CD_PER_RAD
				+ CD_ROUND;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) cd_s6[j] <= m_cd[j][47:30];
			clip_s6 <= cc_q[NSTEP];
		end
	end

	always_comb begin
		pitch_w = 20'sd9000 + 20'(cd_s6[0]);
		roll_w = 20'(cd_s6[1]);
		yaw_w = 20'sd9000 - 20'(cd_s6[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pitch_w < 0) pitch_s7 <= 15'd0;
			else if (pitch_w > 20'sd18000) pitch_s7 <= 15'd18000;
			else pitch_s7 <= pitch_w[14:0];
			if (roll_w < -20'sd18000) roll_s7 <= -16'sd18000;
			else if (roll_w > 20'sd18000) roll_s7 <= 16'sd18000;
			else roll_s7 <= roll_w[15:0];
			if (yaw_w < -20'sd9000) yaw_s7 <= -16'sd9000;
			else if (yaw_w > 20'sd27000) yaw_s7 <= 16'sd27000;
			else yaw_s7 <= yaw_w[15:0];
			clip_s7 <= clip_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NSTEP; i++) cv_q[i] <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			cv_q[0] <= dly_v_q[DLY];
			for (int i = 1; i <= NSTEP; i++) cv_q[i] <= cv_q[i-1];
			v_s6 <= cv_q[NSTEP];
			v_s7 <= v_s6;
		end
	end

	assign out_ready = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (out_ready) out_v_q <= v_s7;
			else if (v_s7) skid_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_ready) begin
				out_pitch_q <= pitch_s7;
				out_roll_q <= roll_s7;
				out_yaw_q <= yaw_s7;
				out_clip_q <= clip_s7;
			end else begin
				skid_pitch_q <= pitch_s7;
				skid_roll_q <= roll_s7;
				skid_yaw_q <= yaw_s7;
				skid_clip_q <= clip_s7;
			end
		end else if (out_ready) begin
			out_pitch_q <= skid_pitch_q;
			out_roll_q <= skid_roll_q;
			out_yaw_q <= skid_yaw_q;
			out_clip_q <= skid_clip_q;
		end
	end

	assign out_valid = out_v_q;
	assign pitch_centideg = out_pitch_q;
	assign roll_centideg = out_roll_q;
	assign yaw_centideg = out_yaw_q;
	assign asin_clamped = out_clip_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("Skid register full while the output register is empty.");

	a_empty_no_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |=> !skid_v_q)
		else $error("Skid register filled although the output register could accept.");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && !out_stall |=> !skid_v_q && out_v_q)
		else $error("Skid register did not drain into the output register.");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_pitch_q <= 15'd18000) && (out_roll_q <= 16'sd18000)
			&& (out_roll_q >= -16'sd18000) && (out_yaw_q <= 16'sd27000)
			&& (out_yaw_q >= -16'sd9000))
		else $error("Result angle outside its range.");

endmodule
